[hdl/drd_pkg.sv]
// Package for the display reply deframer: packet type bytes, event kind codes,
// and the command and status structs between controller and datapath.
// No dependencies.
`default_nettype none

package drd_pkg;

  localparam int unsigned BUFFER_DEPTH = 64;

  localparam logic [7:0] TERM_BYTE   = 8'hFF;
  localparam logic [7:0] TYPE_BUTTON = 8'h65;
  localparam logic [7:0] TYPE_PAGE   = 8'h66;
  localparam logic [7:0] TYPE_POS    = 8'h67;
  localparam logic [7:0] TYPE_POS_SL = 8'h68;
  localparam logic [7:0] TYPE_TEXT   = 8'h70;
  localparam logic [7:0] TYPE_NUMBER = 8'h71;
  localparam logic [7:0] TYPE_SLEEP  = 8'h86;
  localparam logic [7:0] TYPE_WAKE   = 8'h87;

  localparam logic [2:0] KIND_BUTTON   = 3'd0;
  localparam logic [2:0] KIND_PAGE     = 3'd1;
  localparam logic [2:0] KIND_POS      = 3'd2;
  localparam logic [2:0] KIND_TEXT     = 3'd3;
  localparam logic [2:0] KIND_NUMBER   = 3'd4;
  localparam logic [2:0] KIND_SLEEP    = 3'd5;
  localparam logic [2:0] KIND_WAKE     = 3'd6;
  localparam logic [2:0] KIND_OVERFLOW = 3'd7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // store the incoming byte
    logic check;      // decode the buffer, latch a pending result
    logic load_pend;  // move the pending result into the output register
    logic text_read;  // read the next text byte from the buffer memory
    logic load_text;  // move the text byte into the output register
  } drd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_single; // an overflow, or the decoded packet, gives exactly one result
    logic has_text;   // the decoded packet is a non-empty text
    logic text_last;  // the current text byte is the final one
    logic out_free;   // the output register can take a result this cycle
  } drd_sts_t;

endpackage

`default_nettype wire

[hdl/display_reply_deframer.sv]
// Display reply deframer. Input channel: one received byte per item
// (in_valid_i / in_ready_o). Output channel: one event per item
// (out_valid_o / out_ready_i), with last_of_run_o on the final event of a byte.
// Each accepted byte goes into a packet buffer. When the buffer holds more than
// three bytes ending in three 0xFF bytes, the type byte is decoded and the
// buffer is cleared. Text packets give one event per payload byte.
// Sequence: a byte is taken in the idle state, decoded in the check state, and a
// single event is loaded into the output register in the single state once the
// output register is free. Each text payload byte is read through the one read
// port of the buffer memory into its registered read data, then loaded into the
// output register.
// The output register holds a finished event while the next byte is taken; if
// the receiver stalls, the block waits before loading a further event and the
// input channel stays not ready until that event is stored.
// Reset empties the buffer and the output register; the buffer memory itself
// is not cleared, as only stored positions are ever read.
`default_nettype none

module display_reply_deframer #(
  parameter int unsigned BufferDepth = drd_pkg::BUFFER_DEPTH
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [2:0]  event_kind_o,
  output logic [7:0]  page_id_o,
  output logic [7:0]  component_id_o,
  output logic        pressed_o,
  output logic [15:0] pos_x_o,
  output logic [15:0] pos_y_o,
  output logic        asleep_flag_o,
  output logic [31:0] number_value_o,
  output logic [7:0]  text_byte_o,
  output logic        text_valid_o,
  output logic        last_of_run_o
);
  import drd_pkg::*;

  // Command and status between the controller and the datapath.
  drd_cmd_t cmd;
  drd_sts_t sts;

  drd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath owns the buffer, the decoder and the output register.
  drd_datapath #(
    .BufferDepth (BufferDepth)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_byte_i      (rx_byte_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_kind_o   (event_kind_o),
    .page_id_o      (page_id_o),
    .component_id_o (component_id_o),
    .pressed_o      (pressed_o),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .asleep_flag_o  (asleep_flag_o),
    .number_value_o (number_value_o),
    .text_byte_o    (text_byte_o),
    .text_valid_o   (text_valid_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

`default_nettype wire

[hdl/drd_ctrl.sv]
// Controller state machine of the display reply deframer.
// Depends on drd_pkg for the command and status structs.
`default_nettype none

module drd_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  drd_pkg::drd_sts_t sts_i,
  output drd_pkg::drd_cmd_t cmd_o
);
  import drd_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE      = 5'b00001,
    S_CHECK     = 5'b00010,
    S_SINGLE    = 5'b00100,
    S_TEXT_RD   = 5'b01000,
    S_TEXT_EMIT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        if (sts_i.has_single) begin
          state_d = S_SINGLE;
        end else if (sts_i.has_text) begin
          state_d = S_TEXT_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SINGLE: begin
        if (sts_i.out_free) begin
          cmd_o.load_pend = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_TEXT_RD: begin
        cmd_o.text_read = 1'b1;
        state_d         = S_TEXT_EMIT;
      end
      S_TEXT_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.load_text = 1'b1;
          state_d         = sts_i.text_last ? S_IDLE : S_TEXT_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[hdl/drd_datapath.sv]
// Datapath of the display reply deframer: packet buffer memory, header and
// tail byte registers, decoder, pending result and output register.
// Depends on drd_pkg for constants and the command and status structs.
`default_nettype none

module drd_datapath #(
  parameter int unsigned BufferDepth = drd_pkg::BUFFER_DEPTH
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire  [7:0]        rx_byte_i,
  input  drd_pkg::drd_cmd_t cmd_i,
  output drd_pkg::drd_sts_t sts_o,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output logic [2:0]        event_kind_o,
  output logic [7:0]        page_id_o,
  output logic [7:0]        component_id_o,
  output logic              pressed_o,
  output logic [15:0]       pos_x_o,
  output logic [15:0]       pos_y_o,
  output logic              asleep_flag_o,
  output logic [31:0]       number_value_o,
  output logic [7:0]        text_byte_o,
  output logic              text_valid_o,
  output logic              last_of_run_o
);
  import drd_pkg::*;

  localparam int unsigned FW = $clog2(BufferDepth + 1);
  localparam int unsigned AW = $clog2(BufferDepth);

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  page;
    logic [7:0]  comp;
    logic        pressed;
    logic [15:0] x;
    logic [15:0] y;
    logic        asleep;
    logic [31:0] num;
    logic [7:0]  tbyte;
    logic        tvalid;
  } result_t;

  logic [7:0]    mem [BufferDepth];
  logic [7:0]    rd_q;
  logic [FW-1:0] fill_q;
  logic [1:0]    trail_q;
  logic          ovf_q;
  logic [7:0]    hdr_q [6];
  logic [7:0]    hist_q [7];
  logic [FW-1:0] ptr_q;
  logic [FW-1:0] tleft_q;
  result_t       pend_q, pend_d;
  result_t       out_q;
  logic          out_last_q;
  logic          out_valid_q;

  logic          full;
  logic          is_ff;
  logic [FW-1:0] wr_idx;
  logic [7:0]    hb [6];
  logic [7:0]    tb [4];
  logic          complete;
  logic          known;
  result_t       text_res;

  assign full   = (fill_q == FW'(BufferDepth));
  assign is_ff  = (rx_byte_i == TERM_BYTE);
  assign wr_idx = full ? '0 : fill_q;

  // Header and tail bytes read as zero beyond the stored length.
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      hb[i] = (FW'(i) < fill_q) ? hdr_q[i] : 8'h00;
    end
    for (int k = 0; k < 4; k++) begin
      tb[k] = (FW'(k + 4) <= fill_q) ? hist_q[k + 3] : 8'h00;
    end
  end

  assign complete = !ovf_q && (fill_q > FW'(3)) && (trail_q == 2'd3);

  always_comb begin
    pend_d = '0;
    known  = 1'b1;
    if (ovf_q) begin
      pend_d.kind = KIND_OVERFLOW;
    end else begin
      case (hb[0])
        TYPE_BUTTON: begin
          pend_d.kind    = KIND_BUTTON;
          pend_d.page    = hb[1];
          pend_d.comp    = hb[2];
          pend_d.pressed = (hb[3] == 8'h01);
        end
        TYPE_PAGE: begin
          pend_d.kind = KIND_PAGE;
          pend_d.page = hb[1];
        end
        TYPE_POS, TYPE_POS_SL: begin
          pend_d.kind    = KIND_POS;
          pend_d.x       = {hb[1], hb[2]};
          pend_d.y       = {hb[3], hb[4]};
          pend_d.pressed = (hb[5] == 8'h01);
          pend_d.asleep  = (hb[0] == TYPE_POS_SL);
        end
        TYPE_TEXT: begin
          pend_d.kind = KIND_TEXT;
        end
        TYPE_NUMBER: begin
          pend_d.kind = KIND_NUMBER;
          pend_d.num  = {tb[0], tb[1], tb[2], tb[3]};
        end
        TYPE_SLEEP: pend_d.kind = KIND_SLEEP;
        TYPE_WAKE:  pend_d.kind = KIND_WAKE;
        default:    known = 1'b0;
      endcase
    end
  end

  // A text result carries only the byte read from the buffer.
  always_comb begin
    text_res        = '0;
    text_res.kind   = KIND_TEXT;
    text_res.tbyte  = rd_q;
    text_res.tvalid = 1'b1;
  end

  always_comb begin
    sts_o            = '0;
    sts_o.has_single = ovf_q || (complete && known &&
                       ((hb[0] != TYPE_TEXT) || (fill_q == FW'(4))));
    sts_o.has_text   = complete && (hb[0] == TYPE_TEXT) && (fill_q > FW'(4));
    sts_o.text_last  = (tleft_q == FW'(1));
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  // Buffer memory: written on accept, read one text byte at a time.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mem[wr_idx[AW-1:0]] <= rx_byte_i;
    end
    if (cmd_i.text_read) begin
      rd_q <= mem[ptr_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      for (int i = 0; i < 6; i++) begin
        if (wr_idx == FW'(i)) begin
          hdr_q[i] <= rx_byte_i;
        end
      end
      hist_q[0] <= rx_byte_i;
      for (int k = 1; k < 7; k++) begin
        hist_q[k] <= hist_q[k - 1];
      end
    end
    if (cmd_i.check) begin
      pend_q  <= pend_d;
      ptr_q   <= FW'(1);
      tleft_q <= fill_q - FW'(4);
    end
    if (cmd_i.load_text) begin
      ptr_q   <= ptr_q + FW'(1);
      tleft_q <= tleft_q - FW'(1);
    end
    if (cmd_i.load_pend) begin
      out_q      <= pend_q;
      out_last_q <= 1'b1;
    end else if (cmd_i.load_text) begin
      out_q      <= text_res;
      out_last_q <= (tleft_q == FW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      trail_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        ovf_q <= full;
        if (full) begin
          fill_q  <= FW'(1);
          trail_q <= is_ff ? 2'd1 : 2'd0;
        end else begin
          fill_q  <= fill_q + FW'(1);
          trail_q <= !is_ff ? 2'd0 : ((trail_q == 2'd3) ? 2'd3 : trail_q + 2'd1);
        end
      end else if (cmd_i.check && complete) begin
        fill_q  <= '0;
        trail_q <= '0;
      end
      if (cmd_i.load_pend || cmd_i.load_text) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_kind_o   = out_q.kind;
  assign page_id_o      = out_q.page;
  assign component_id_o = out_q.comp;
  assign pressed_o      = out_q.pressed;
  assign pos_x_o        = out_q.x;
  assign pos_y_o        = out_q.y;
  assign asleep_flag_o  = out_q.asleep;
  assign number_value_o = out_q.num;
  assign text_byte_o    = out_q.tbyte;
  assign text_valid_o   = out_q.tvalid;
  assign last_of_run_o  = out_last_q;

endmodule

`default_nettype wire
